>>> hdl/pqs_pkg.sv
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared types and codes for the process state queue block.
// ----------------------------------------------------------------------------
package pqs_pkg;

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_READY_IO  = 3'd1,
    OP_IO_READY  = 3'd2,
    OP_READY_RUN = 3'd3,
    OP_RUN_READY = 3'd4,
    OP_TERM      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    PS_READY = 2'd0,
    PS_IO    = 2'd1,
    PS_RUN   = 2'd2,
    PS_TERM  = 2'd3
  } proc_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_REPORT
  } fsm_t;

  typedef struct packed {
    logic remove;
    logic append;
  } row_ctrl_t;

  typedef struct packed {
    logic hit;
    logic full;
  } row_stat_t;

endpackage

>>> hdl/pqs_cell.sv
// ----------------------------------------------------------------------------
// pqs_cell
// One queue slot: holds an ID, flags a match, and pulls its upper neighbor's
// entry when it or a lower slot matches during removal.
// ----------------------------------------------------------------------------
module pqs_cell #(
  parameter int INDEX   = 0,
  parameter int ID_BITS = 8,
  parameter int LEN_W   = 5
) (
  input  logic               clk,
  input  pqs_pkg::row_ctrl_t ctrl,
  input  logic [LEN_W-1:0]   len,
  input  logic [ID_BITS-1:0] id,
  input  logic [ID_BITS-1:0] data_up,
  input  logic               match_in,
  output logic               match_out,
  output logic [ID_BITS-1:0] data
);

  logic valid;

  assign valid     = len > LEN_W'(INDEX);
  assign match_out = match_in | (valid & (data == id));

  always_ff @(posedge clk) begin
    if (ctrl.remove && match_out) begin
      data <= data_up;
    end else if (ctrl.append && (len == LEN_W'(INDEX))) begin
      data <= id;
    end
  end

endmodule

>>> hdl/pqs_row.sv
// ----------------------------------------------------------------------------
// pqs_row
// One ordered queue built as a chain of cells; removes the first copy of the
// ID per cycle and appends at the tail.
// ----------------------------------------------------------------------------
module pqs_row #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8,
  parameter int LEN_W   = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  pqs_pkg::row_ctrl_t ctrl,
  input  logic [ID_BITS-1:0] id,
  output pqs_pkg::row_stat_t stat,
  output logic [LEN_W-1:0]   len,
  output logic [ID_BITS-1:0] front
);

  logic [ID_BITS-1:0] data [DEPTH];
  logic [DEPTH:0]     match;
  pqs_pkg::row_ctrl_t cell_ctrl;

  assign match[0]       = 1'b0;
  assign stat.hit       = match[DEPTH];
  assign stat.full      = len == LEN_W'(DEPTH);
  assign cell_ctrl.remove = ctrl.remove;
  assign cell_ctrl.append = ctrl.append & ~stat.full;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0] up;
    if (i == DEPTH - 1) begin : g_last
      assign up = data[i];
    end else begin : g_mid
      assign up = data[i+1];
    end
    pqs_cell #(
      .INDEX  (i),
      .ID_BITS(ID_BITS),
      .LEN_W  (LEN_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .len      (len),
      .id       (id),
      .data_up  (up),
      .match_in (match[i]),
      .match_out(match[i+1]),
      .data     (data[i])
    );
  end

  assign front = (len != '0) ? data[0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cell_ctrl.remove && stat.hit) begin
      len <= len - LEN_W'(1);
    end else if (cell_ctrl.append) begin
      len <= len + LEN_W'(1);
    end
  end

endmodule

>>> hdl/process_state_queues_core.sv
// ----------------------------------------------------------------------------
// process_state_queues_core
// Ready, I/O wait and running process queues driven by one-beat commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The block then
// removes one copy of the ID from each source queue per cycle, appends in the
// first cycle that finds no further copy, and shows the result for one cycle
// with done high. The block keeps removing as long as a source queue still
// holds a copy; busy is low in the result cycle, so the next command may be
// taken there. Results cannot be held off.
// ----------------------------------------------------------------------------
module process_state_queues_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] opcode,
  input  logic [7:0] process_id,
  output logic       done,
  output logic [1:0] new_state,
  output logic       was_found,
  output logic       dest_full,
  output logic [4:0] ready_count,
  output logic [4:0] io_count,
  output logic [4:0] run_count,
  output logic [7:0] ready_front
);

  localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

  pqs_pkg::fsm_t      state, state_next;
  pqs_pkg::op_t       op;
  logic [ID_BITS-1:0] id;
  logic               found;
  logic               full;

  logic rm_ready, rm_io, rm_run;
  logic dst_ready, dst_io, dst_run;
  logic any_hit, dst_is_full;
  logic accept;

  pqs_pkg::row_ctrl_t ready_ctrl, io_ctrl, run_ctrl;
  pqs_pkg::row_stat_t ready_stat, io_stat, run_stat;
  logic [LEN_W-1:0]   ready_len, io_len, run_len;
  logic [ID_BITS-1:0] ready_head, io_head, run_head;

  always_comb begin
    rm_ready  = 1'b0;
    rm_io     = 1'b0;
    rm_run    = 1'b0;
    dst_ready = 1'b0;
    dst_io    = 1'b0;
    dst_run   = 1'b0;
    new_state = pqs_pkg::PS_READY;
    case (op)
      pqs_pkg::OP_ADD: begin
        dst_ready = 1'b1;
      end
      pqs_pkg::OP_READY_IO: begin
        rm_ready  = 1'b1;
        dst_io    = 1'b1;
        new_state = pqs_pkg::PS_IO;
      end
      pqs_pkg::OP_IO_READY: begin
        rm_io     = 1'b1;
        dst_ready = 1'b1;
      end
      pqs_pkg::OP_READY_RUN: begin
        rm_ready  = 1'b1;
        dst_run   = 1'b1;
        new_state = pqs_pkg::PS_RUN;
      end
      pqs_pkg::OP_RUN_READY: begin
        rm_run    = 1'b1;
        dst_ready = 1'b1;
      end
      pqs_pkg::OP_TERM: begin
        rm_ready  = 1'b1;
        rm_io     = 1'b1;
        rm_run    = 1'b1;
        new_state = pqs_pkg::PS_TERM;
      end
      default: begin
      end
    endcase
  end

  assign any_hit = (rm_ready & ready_stat.hit) | (rm_io & io_stat.hit)
                 | (rm_run & run_stat.hit);
  assign dst_is_full = (dst_ready & ready_stat.full) | (dst_io & io_stat.full)
                     | (dst_run & run_stat.full);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pqs_pkg::ST_IDLE: begin
        if (start) state_next = pqs_pkg::ST_REMOVE;
      end
      pqs_pkg::ST_REMOVE: begin
        if (!any_hit) state_next = pqs_pkg::ST_REPORT;
      end
      pqs_pkg::ST_REPORT: begin
        state_next = start ? pqs_pkg::ST_REMOVE : pqs_pkg::ST_IDLE;
      end
      default: state_next = pqs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy              = 1'b0;
    done              = 1'b0;
    ready_ctrl        = '0;
    io_ctrl           = '0;
    run_ctrl          = '0;
    case (state)
      pqs_pkg::ST_REMOVE: begin
        busy              = 1'b1;
        ready_ctrl.remove = rm_ready;
        io_ctrl.remove    = rm_io;
        run_ctrl.remove   = rm_run;
        ready_ctrl.append = dst_ready & ~any_hit;
        io_ctrl.append    = dst_io & ~any_hit;
        run_ctrl.append   = dst_run & ~any_hit;
      end
      pqs_pkg::ST_REPORT: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pqs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= pqs_pkg::op_t'(opcode);
      id    <= ID_BITS'(process_id);
      found <= 1'b0;
      full  <= 1'b0;
    end else if (state == pqs_pkg::ST_REMOVE) begin
      if (any_hit) begin
        found <= 1'b1;
      end else begin
        full <= dst_is_full;
      end
    end
  end

  pqs_row #(.DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS), .LEN_W(LEN_W)) u_ready (
    .clk(clk), .rst(rst), .ctrl(ready_ctrl), .id(id),
    .stat(ready_stat), .len(ready_len), .front(ready_head)
  );

  pqs_row #(.DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS), .LEN_W(LEN_W)) u_io (
    .clk(clk), .rst(rst), .ctrl(io_ctrl), .id(id),
    .stat(io_stat), .len(io_len), .front(io_head)
  );

  pqs_row #(.DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS), .LEN_W(LEN_W)) u_run (
    .clk(clk), .rst(rst), .ctrl(run_ctrl), .id(id),
    .stat(run_stat), .len(run_len), .front(run_head)
  );

  // heads of the io and running queues are not reported
  logic unused_heads;
  assign unused_heads = ^{io_head, run_head};

  assign was_found   = found;
  assign dest_full   = full;
  assign ready_count = 5'(ready_len);
  assign io_count    = 5'(io_len);
  assign run_count   = 5'(run_len);
  assign ready_front = 8'(ready_head);

endmodule

>>> dv/process_state_queues_core_test.sv
// ----------------------------------------------------------------------------
// process_state_queues_core_test
// Self-checking bench for the ready / I/O wait / running process queues.
// A driver issues commands over the start/busy handshake, a local queue model
// predicts every result beat, and a monitor checks each done beat in order.
// Directed commands come first, then pool-based random traffic that fills
// and drains the queues, under several sender idle rates.
// ----------------------------------------------------------------------------
module process_state_queues_core_test;

  localparam int DEPTH      = 16;
  localparam int NUM_CMDS   = 500;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYC   = 40;

  typedef struct packed {
    pqs_pkg::proc_state_t state;
    logic                 found;
    logic                 full;
    logic [4:0]           n_ready;
    logic [4:0]           n_io;
    logic [4:0]           n_run;
    logic [7:0]           front;
  } outcome_t;

  typedef struct {
    pqs_pkg::op_t op;
    logic [7:0]   pid;
    int unsigned  idle_pct;
    bit           drain;
  } cmd_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [2:0] opcode = '0;
  logic [7:0] process_id = '0;
  logic       busy;
  logic       done;
  logic [1:0] new_state;
  logic       was_found;
  logic       dest_full;
  logic [4:0] ready_count;
  logic [4:0] io_count;
  logic [4:0] run_count;
  logic [7:0] ready_front;

  process_state_queues_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .process_id  (process_id),
    .done        (done),
    .new_state   (new_state),
    .was_found   (was_found),
    .dest_full   (dest_full),
    .ready_count (ready_count),
    .io_count    (io_count),
    .run_count   (run_count),
    .ready_front (ready_front)
  );

  // model queues, head at index 0
  logic [7:0] ready_q[$];
  logic [7:0] io_q[$];
  logic [7:0] run_q[$];

  cmd_t     pending_cmds[$];
  outcome_t expected_outcomes[$];

  int n_queued    = 0;
  int n_issued    = 0;
  int n_done_seen = 0;
  int mismatches  = 0;
  int n_results   = 0;
  int n_full      = 0;
  int n_found     = 0;
  int op_tally[6];
  int idle_cyc    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit purge_id(ref logic [7:0] q[$], input logic [7:0] id);
    bit hit;
    hit = 1'b0;
    for (int i = q.size() - 1; i >= 0; i--) begin
      if (q[i] == id) begin
        q.delete(i);
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic bit append_id(ref logic [7:0] q[$], input logic [7:0] id);
    if (q.size() >= DEPTH) return 1'b1;
    q.push_back(id);
    return 1'b0;
  endfunction

  function automatic outcome_t apply_command(pqs_pkg::op_t op, logic [7:0] id);
    outcome_t o;
    bit       hit;
    o = '0;
    case (op)
      pqs_pkg::OP_ADD: begin
        o.state = pqs_pkg::PS_READY;
        o.full  = append_id(ready_q, id);
      end
      pqs_pkg::OP_READY_IO: begin
        o.state = pqs_pkg::PS_IO;
        o.found = purge_id(ready_q, id);
        o.full  = append_id(io_q, id);
      end
      pqs_pkg::OP_IO_READY: begin
        o.state = pqs_pkg::PS_READY;
        o.found = purge_id(io_q, id);
        o.full  = append_id(ready_q, id);
      end
      pqs_pkg::OP_READY_RUN: begin
        o.state = pqs_pkg::PS_RUN;
        o.found = purge_id(ready_q, id);
        o.full  = append_id(run_q, id);
      end
      pqs_pkg::OP_RUN_READY: begin
        o.state = pqs_pkg::PS_READY;
        o.found = purge_id(run_q, id);
        o.full  = append_id(ready_q, id);
      end
      pqs_pkg::OP_TERM: begin
        o.state = pqs_pkg::PS_TERM;
        hit     = purge_id(run_q, id);
        hit     = purge_id(ready_q, id) | hit;
        hit     = purge_id(io_q, id) | hit;
        o.found = hit;
      end
      default: ;
    endcase
    o.n_ready = 5'(ready_q.size());
    o.n_io    = 5'(io_q.size());
    o.n_run   = 5'(run_q.size());
    o.front   = (ready_q.size() > 0) ? ready_q[0] : 8'd0;
    return o;
  endfunction

  // driver
  always @(posedge clk) begin : drive
    cmd_t nxt;
    bit   go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_outcomes.push_back(apply_command(pqs_pkg::op_t'(opcode), process_id));
        op_tally[opcode]++;
        n_issued++;
      end
      if (done) n_done_seen++;
      if (!(start && busy)) begin
        go = 1'b0;
        if (pending_cmds.size() > 0) begin
          nxt = pending_cmds[0];
          go  = ($urandom_range(99) >= nxt.idle_pct) &&
                !(nxt.drain && n_issued > n_done_seen);
        end
        if (go) begin
          start      <= 1'b1;
          opcode     <= nxt.op;
          process_id <= nxt.pid;
          void'(pending_cmds.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    outcome_t got;
    outcome_t want;
    if (!rst && done) begin
      got = '{pqs_pkg::proc_state_t'(new_state), was_found, dest_full,
              ready_count, io_count, run_count, ready_front};
      n_results++;
      if (got.full === 1'b1) n_full++;
      if (got.found === 1'b1) n_found++;
      if (expected_outcomes.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: state %0d rdy %0d io %0d run %0d",
                   got.state, got.n_ready, got.n_io, got.n_run);
        mismatches++;
      end else begin
        want = expected_outcomes.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("result %0d mismatch (state found full rdy io run front):",
                     n_results);
            $display("  exp %0d %0d %0d %0d %0d %0d %0h, got %0d %0d %0d %0d %0d %0d %0h",
                     want.state, want.found, want.full, want.n_ready,
                     want.n_io, want.n_run, want.front, got.state, got.found,
                     got.full, got.n_ready, got.n_io, got.n_run, got.front);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("[process_state_queues_core] ERROR");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  int unsigned phase_pct[6] = '{0, 70, 26, 0, 70, 26};
  int          cur_phase = 0;
  bit          hold_next = 1'b0;

  task automatic queue_cmd(pqs_pkg::op_t op, logic [7:0] pid);
    cmd_t c;
    int   ph;
    ph = (n_queued * 6) / NUM_CMDS;
    if (ph > 5) ph = 5;
    if (ph != cur_phase) begin
      cur_phase = ph;
      hold_next = 1'b1;
    end
    c.op       = op;
    c.pid      = pid;
    c.idle_pct = phase_pct[ph];
    c.drain    = hold_next;
    hold_next  = 1'b0;
    pending_cmds.push_back(c);
    n_queued++;
  endtask

  function automatic pqs_pkg::op_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 30) return pqs_pkg::OP_ADD;
    if (r < 44) return pqs_pkg::OP_READY_IO;
    if (r < 58) return pqs_pkg::OP_IO_READY;
    if (r < 72) return pqs_pkg::OP_READY_RUN;
    if (r < 86) return pqs_pkg::OP_RUN_READY;
    return pqs_pkg::OP_TERM;
  endfunction

  initial begin : main
    int         kind;
    int         len;
    int         pool_size;
    logic [7:0] pool_base;

    // directed: field extremes, every command, absent IDs, duplicates
    queue_cmd(pqs_pkg::OP_ADD, 8'h00);
    queue_cmd(pqs_pkg::OP_ADD, 8'hFF);
    queue_cmd(pqs_pkg::OP_ADD, 8'hFF);
    queue_cmd(pqs_pkg::OP_READY_IO, 8'hFF);
    queue_cmd(pqs_pkg::OP_READY_IO, 8'h55);
    queue_cmd(pqs_pkg::OP_IO_READY, 8'hFF);
    queue_cmd(pqs_pkg::OP_IO_READY, 8'h33);
    queue_cmd(pqs_pkg::OP_READY_RUN, 8'h00);
    queue_cmd(pqs_pkg::OP_RUN_READY, 8'h00);
    queue_cmd(pqs_pkg::OP_RUN_READY, 8'h12);
    queue_cmd(pqs_pkg::OP_TERM, 8'hFF);
    queue_cmd(pqs_pkg::OP_TERM, 8'h55);
    queue_cmd(pqs_pkg::OP_TERM, 8'h77);
    queue_cmd(pqs_pkg::OP_TERM, 8'h00);
    queue_cmd(pqs_pkg::OP_READY_RUN, 8'hA5);
    hold_next = 1'b1;

    // random episodes over a small ID pool so that moves find their IDs
    pool_base = 8'($urandom_range(255));
    pool_size = $urandom_range(3, 20);
    while (n_queued < NUM_CMDS) begin
      if ($urandom_range(99) < 30) begin
        pool_base = 8'($urandom_range(255));
        pool_size = $urandom_range(3, 20);
      end
      kind = $urandom_range(99);
      if (kind < 45) begin
        len = $urandom_range(10, 30);
        repeat (len)
          queue_cmd(pick_op(), pool_base + 8'($urandom_range(pool_size - 1)));
      end else if (kind < 70) begin
        // fill ready near or past its depth, spill into io and running, move some back
        len = $urandom_range(14, 20);
        repeat (len)
          queue_cmd(pqs_pkg::OP_ADD, pool_base + 8'($urandom_range(pool_size - 1)));
        repeat ($urandom_range(len))
          queue_cmd($urandom_range(1) ? pqs_pkg::OP_READY_RUN : pqs_pkg::OP_READY_IO,
                    pool_base + 8'($urandom_range(pool_size - 1)));
        repeat ($urandom_range(8))
          queue_cmd($urandom_range(1) ? pqs_pkg::OP_RUN_READY : pqs_pkg::OP_IO_READY,
                    pool_base + 8'($urandom_range(pool_size - 1)));
      end else if (kind < 85) begin
        len = $urandom_range(5, 15);
        repeat (len)
          queue_cmd(pqs_pkg::op_t'($urandom_range(5)), 8'($urandom_range(255)));
      end else begin
        for (int i = 0; i < pool_size; i++)
          queue_cmd(pqs_pkg::OP_TERM, pool_base + 8'(i));
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (n_issued < n_queued) @(posedge clk);
    while (expected_outcomes.size() > 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    $display("covered %0d commands (add %0d, rdy>io %0d, io>rdy %0d, rdy>run %0d,",
             n_issued, op_tally[pqs_pkg::OP_ADD], op_tally[pqs_pkg::OP_READY_IO],
             op_tally[pqs_pkg::OP_IO_READY], op_tally[pqs_pkg::OP_READY_RUN]);
    $display("  run>rdy %0d, term %0d); %0d hits, %0d dropped appends, %0d mismatches",
             op_tally[pqs_pkg::OP_RUN_READY], op_tally[pqs_pkg::OP_TERM], n_found,
             n_full, mismatches);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("[process_state_queues_core] OK");
    end else begin
      $display("[process_state_queues_core] ERROR");
    end
    $finish;
  end

endmodule
